### src/picl_pkg.sv
// Shared types and constants for the Q1.15 PI current loop.
// Holds the control word layout, microprogram ROM and register indexes.
// No dependencies; imported by every module of the block.
`default_nettype none

package picl_pkg;

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int DUTY_W   = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int PERIOD_W = 15;
   localparam int ACC_W    = 34;
   localparam int MUL_W    = 17;
   localparam int PC_W     = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD = 8'd3;

   // Reset values.
   localparam logic signed [15:0]   SETPOINT_RST   = 16'sd16384;
   localparam logic signed [15:0]   PROP_GAIN_RST  = 16'sd16384;
   localparam logic signed [15:0]   INTEG_GAIN_RST = 16'sd3276;
   localparam logic [PERIOD_W-1:0]  PWM_PERIOD_RST = 15'd3999;

   // Integrator bounds, plus and minus 2^30.
   localparam logic signed [ACC_W-1:0] INTEG_POS = 34'sh0_4000_0000;
   localparam logic signed [ACC_W-1:0] INTEG_NEG = -INTEG_POS;

   // Datapath operation codes.
   localparam logic [2:0] ALU_NOP      = 3'd0;
   localparam logic [2:0] ALU_ERR      = 3'd1;
   localparam logic [2:0] ALU_ADD_INT  = 3'd2;
   localparam logic [2:0] ALU_CLAMP    = 3'd3;
   localparam logic [2:0] ALU_STORE    = 3'd4;
   localparam logic [2:0] ALU_ADD_PROP = 3'd5;
   localparam logic [2:0] ALU_SAT      = 3'd6;
   localparam logic [2:0] ALU_DUTY     = 3'd7;

   // Multiplier operand select.
   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_EI   = 2'd1;
   localparam logic [1:0] MUL_EP   = 2'd2;
   localparam logic [1:0] MUL_QP   = 2'd3;

   // Jump conditions.
   localparam logic [1:0] JMP_NONE     = 2'd0;
   localparam logic [1:0] JMP_ALWAYS   = 2'd1;
   localparam logic [1:0] JMP_IN_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]      alu_op;
      logic [1:0]      mul_sel;
      logic [1:0]      cond;
      logic [PC_W-1:0] target;
      logic            last;
   } ctrl_word_type;

   typedef struct packed {
      logic acc_in_range;
   } dp_status_type;

   localparam ctrl_word_type CTRL_IDLE = '{ALU_NOP, MUL_NONE, JMP_NONE, 4'd0, 1'b0};

   // Microprogram: one control word per step.
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = CTRL_IDLE;
      unique case (pc)
         4'd0: w = '{ALU_ERR,      MUL_NONE, JMP_NONE,     4'd0, 1'b0};
         4'd1: w = '{ALU_NOP,      MUL_EI,   JMP_NONE,     4'd0, 1'b0};
         4'd2: w = '{ALU_ADD_INT,  MUL_NONE, JMP_NONE,     4'd0, 1'b0};
         4'd3: w = '{ALU_NOP,      MUL_NONE, JMP_IN_RANGE, 4'd5, 1'b0};
         4'd4: w = '{ALU_CLAMP,    MUL_NONE, JMP_NONE,     4'd0, 1'b0};
         4'd5: w = '{ALU_STORE,    MUL_EP,   JMP_NONE,     4'd0, 1'b0};
         4'd6: w = '{ALU_ADD_PROP, MUL_NONE, JMP_NONE,     4'd0, 1'b0};
         4'd7: w = '{ALU_SAT,      MUL_NONE, JMP_NONE,     4'd0, 1'b0};
         4'd8: w = '{ALU_NOP,      MUL_QP,   JMP_NONE,     4'd0, 1'b0};
         4'd9: w = '{ALU_DUTY,     MUL_NONE, JMP_NONE,     4'd0, 1'b1};
         default: w = CTRL_IDLE;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### src/picl_ifs.sv
// Valid/ready channel interfaces for the PI current loop.
// Depends on picl_pkg for field widths.
`default_nettype none

interface picl_req_if import picl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface picl_rsp_if import picl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] pwm_duty;
   modport source (output valid, output pwm_duty, input ready);
   modport sink   (input valid, input pwm_duty, output ready);
endinterface

interface picl_csr_if import picl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/picl_seq.sv
// Microprogram sequencer: step counter, ROM fetch and conditional jumps.
// Depends on picl_pkg for the control word and ROM.
`default_nettype none

module picl_seq import picl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          stall,
   input  wire dp_status_type status,
   output ctrl_word_type      ctrl,
   output logic               busy
);

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   ctrl_word_type   word;
   logic            advance;
   logic            taken;

   assign word    = ucode_rom(pc_ff);
   assign advance = busy_ff && !(word.last && stall);
   assign ctrl    = advance ? word : CTRL_IDLE;
   assign busy    = busy_ff;

   always_comb begin
      unique case (word.cond)
         JMP_ALWAYS:   taken = 1'b1;
         JMP_IN_RANGE: taken = status.acc_in_range;
         default:      taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = '0;
         busy_in = 1'b1;
      end else if (advance) begin
         if (word.last) begin
            pc_in   = '0;
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

### src/picl_dp.sv
// Datapath of the PI loop: error, one shared 17x17 multiplier, accumulator,
// integrator, saturation. Driven by picl_seq control words; uses picl_pkg.
`default_nettype none

module picl_dp import picl_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic signed [15:0]         setpoint,
   input  wire logic signed [15:0]         prop_gain,
   input  wire logic signed [15:0]         integ_gain,
   input  wire logic [PERIOD_W-1:0]        pwm_period,
   input  wire ctrl_word_type              ctrl,
   output dp_status_type                   status,
   output logic [DUTY_W-1:0]               duty
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [15:0]         err_ff, err_in;
   logic signed [15:0]         q_ff, q_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    prod_ff;
   logic signed [31:0]         integ_ff, integ_in;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [ACC_W-1:0]    prod_in;
   logic signed [18:0]         acc_sh;
   logic signed [18:0]         prod_sh;

   // Operand select for the shared multiplier.
   always_comb begin
      case (ctrl.mul_sel)
         MUL_EI: begin
            mul_a = {err_ff[15], err_ff};
            mul_b = {integ_gain[15], integ_gain};
         end
         MUL_EP: begin
            mul_a = {err_ff[15], err_ff};
            mul_b = {prop_gain[15], prop_gain};
         end
         MUL_QP: begin
            mul_a = {q_ff[15], q_ff};
            mul_b = {1'b0, pwm_period, 1'b0};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign acc_sh  = acc_ff[ACC_W-1:15];
   assign prod_sh = prod_ff[ACC_W-1:15];

   assign status.acc_in_range = (acc_ff <= INTEG_POS) && (acc_ff >= INTEG_NEG);

   always_comb begin
      err_in   = err_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      integ_in = integ_ff;
      case (ctrl.alu_op)
         ALU_ERR:      err_in = setpoint - {sample_ff[SAMPLE_W-1], sample_ff, 5'b0};
         ALU_ADD_INT:  acc_in = {{2{integ_ff[31]}}, integ_ff} + prod_ff;
         ALU_CLAMP:    acc_in = acc_ff[ACC_W-1] ? INTEG_NEG : INTEG_POS;
         ALU_STORE:    integ_in = acc_ff[31:0];
         ALU_ADD_PROP: acc_in = acc_ff + {prod_ff[ACC_W-2:0], 1'b0};
         ALU_SAT: begin
            if (acc_sh > 19'sd32767)
               q_in = 16'sh7FFF;
            else if (acc_sh < -19'sd32768)
               q_in = 16'sh8000;
            else
               q_in = acc_sh[15:0];
         end
         default: ;
      endcase
   end

   // Floor-shifted duty; negative clamps to zero, overflow to full scale.
   always_comb begin
      if (prod_sh[18])
         duty = '0;
      else if (|prod_sh[17:16])
         duty = '1;
      else
         duty = prod_sh[15:0];
   end

   always_ff @(posedge clock) begin
      if (load)
         sample_ff <= sample;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      if (ctrl.mul_sel != MUL_NONE)
         prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         integ_ff <= '0;
      else
         integ_ff <= integ_in;
   end

endmodule

`default_nettype wire

### src/pi_current_loop_q15.sv
// Q1.15 PI current loop with integrator clamp - top level.
// Depends on picl_pkg, picl_ifs, picl_seq and picl_dp.
//
// Use:
//   req_chan carries one signed 10-bit converter sample per request.
//   rsp_chan returns one pwm_duty value (0 .. 2*pwm_period) per request.
//   csr_chan writes setpoint (0), prop_gain (1), integ_gain (2) and
//   pwm_period (3); other indexes are dropped. Write only while idle.
// Timing:
//   A request starts a 10-step microprogram (9 steps when the integrator
//   stays inside +/-2^30), one step per clock on a single 17x17 multiplier
//   unless the last step stalls. The response is registered after the
//   final step; a new request waits until the sequencer is idle again.
//   req_chan.ready is high whenever the sequencer is idle and out of reset,
//   so the next request enters while an earlier response still waits in
//   the output register.
// Reset:
//   Synchronous, active high. Configuration registers return to their
//   defaults, the integrator clears to zero and no response is pending.
// Stall:
//   If the receiver holds rsp_chan.ready low, the response register holds
//   its value and a following request halts at its last step until the
//   register frees up; nothing is lost or repeated.
`default_nettype none

module pi_current_loop_q15 import picl_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   picl_req_if.sink   req_chan,
   picl_rsp_if.source rsp_chan,
   picl_csr_if.sink   csr_chan
);

   logic signed [15:0]     setpoint_ff, prop_gain_ff, integ_gain_ff;
   logic [PERIOD_W-1:0]    pwm_period_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]      rsp_duty_ff;
   logic                   busy;
   logic                   start;
   logic                   stall;
   logic                   csr_write;
   ctrl_word_type          ctrl;
   dp_status_type          status;
   logic [DUTY_W-1:0]      duty;

   // Accept a request only when the sequencer is free.
   assign req_chan.ready = !busy && !reset;
   assign start          = req_chan.valid && req_chan.ready;

   // Hold the last step while the output register is still occupied.
   assign stall = rsp_valid_ff && !rsp_chan.ready;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pwm_duty = rsp_duty_ff;

   assign csr_chan.ready = !reset;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   // Configuration registers; extra upper bits are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= SETPOINT_RST;
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         pwm_period_ff <= PWM_PERIOD_RST;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_SETPOINT:   setpoint_ff   <= csr_chan.data;
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_chan.data;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_chan.data;
            CSR_PWM_PERIOD: pwm_period_ff <= csr_chan.data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   picl_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .stall  (stall),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   picl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .load       (start),
      .sample     (req_chan.sample),
      .setpoint   (setpoint_ff),
      .prop_gain  (prop_gain_ff),
      .integ_gain (integ_gain_ff),
      .pwm_period (pwm_period_ff),
      .ctrl       (ctrl),
      .status     (status),
      .duty       (duty)
   );

   // Output register: load on the final step, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready)
         rsp_valid_in = 1'b0;
      if (ctrl.last)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.last)
         rsp_duty_ff <= duty;
   end

endmodule

`default_nettype wire

### src/picl_checker.sv
// Port-level checks for pi_current_loop_q15, bound to the top level.
// Depends on picl_pkg and the top level's channel interfaces.
`default_nettype none

module picl_checker import picl_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DUTY_W-1:0] rsp_duty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_duty))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too soon after request");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty != 16'hFFFF)
      else $error("duty beyond full scale");

endmodule

bind pi_current_loop_q15 picl_checker u_picl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_duty  (rsp_chan.pwm_duty)
);

`default_nettype wire
